>>> rtl/fmd_pkg.sv
package fmd_pkg;

	// Header layout and field widths.
	localparam int HDR_BYTES = 16;
	localparam int HDR_IDX_W = $clog2(HDR_BYTES);
	localparam int LIMIT_W = 17;
	localparam int PAYLOAD_CAP_DEF = 65536;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

	// Header constants.
	localparam logic [7:0] MAGIC_B0 = 8'h46;
	localparam logic [7:0] MAGIC_B1 = 8'h4D;
	localparam logic [7:0] MAGIC_B2 = 8'h47;
	localparam logic [7:0] MAGIC_B3 = 8'h4F;
	localparam logic [7:0] VERSION_OK = 8'd1;
	localparam logic [7:0] TYPE_MIN = 8'd1;
	localparam logic [7:0] TYPE_MAX = 8'd5;
	localparam logic [7:0] TYPE_NOREQ_A = 8'd3;
	localparam logic [7:0] TYPE_NOREQ_B = 8'd5;

	// Decode status codes.
	localparam logic [2:0] ST_INCOMPLETE = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_BADVER = 3'd3;
	localparam logic [2:0] ST_OVERSIZED = 3'd4;

	// Command codes.
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam int OUT_TDATA_W = 88;

	typedef struct packed {
		logic command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic accepted;
		logic [2:0] status;
		logic payload_valid;
		logic [7:0] payload_byte;
		logic header_valid;
		logic [7:0] frame_type;
		logic [31:0] request_id;
		logic [31:0] payload_length;
	} result_t;

endpackage

>>> rtl/framed_message_decoder.sv
// Channel   Direction  Transfer carries
// s_axis    in         tuser: command; tdata: data_byte
// m_axis    out        tdata: one result per input item
// cfg       in         data: size_limit
//
// An item passes through the input register and then through the header/payload
// decode into the result register. A new item is taken every cycle while
// results are taken. The decode state (byte count and status) advances as an
// item enters the result register. Reset clears the control state and sets
// size_limit to 65536. A stalled result holds while one more item waits in the
// input register.
module framed_message_decoder #(
	parameter int PAYLOAD_CAP = fmd_pkg::PAYLOAD_CAP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
	input  logic s_axis_tuser,         // command[0]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// accepted[0], status[3:1], payload_valid[4], payload_byte[12:5],
	// header_valid[13], frame_type[21:14], request_id[53:22],
	// payload_length[85:54], zero[87:86]
	output logic [fmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [fmd_pkg::LIMIT_W-1:0] cfg_data
);
	import fmd_pkg::*;

	logic [LIMIT_W-1:0] size_limit_q;
	item_t up_item, s1_item;
	logic s1_valid, s1_ready;
	result_t res;

	// The limit register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_limit_q <= cfg_data;
		end
	end

	assign up_item.command = s_axis_tuser;
	assign up_item.data_byte = s_axis_tdata;

	fmd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s_axis_tvalid),
		.up_ready (s_axis_tready),
		.up_item  (up_item),
		.dn_valid (s1_valid),
		.dn_ready (s1_ready),
		.dn_item  (s1_item)
	);

	fmd_core #(
		.PAYLOAD_CAP (PAYLOAD_CAP)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.size_limit (size_limit_q),
		.in_valid   (s1_valid),
		.in_ready   (s1_ready),
		.in_item    (s1_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	// Pack the result fields from the lowest bit up.
	assign m_axis_tdata = {2'b00, res.payload_length, res.request_id, res.frame_type,
		res.header_valid, res.payload_byte, res.payload_valid, res.status, res.accepted};

endmodule

>>> rtl/fmd_in_stage.sv
module fmd_in_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  fmd_pkg::item_t up_item,
	output logic dn_valid,
	input  logic dn_ready,
	output fmd_pkg::item_t dn_item
);
	import fmd_pkg::*;

	logic valid_s1;
	item_t item_s1;

	// The stage takes a new transfer whenever it is empty or drains this cycle.
	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			item_s1 <= up_item;
		end
	end

endmodule

>>> rtl/fmd_core.sv
module fmd_core #(
	parameter int PAYLOAD_CAP = fmd_pkg::PAYLOAD_CAP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [fmd_pkg::LIMIT_W-1:0] size_limit,
	input  logic in_valid,
	output logic in_ready,
	input  fmd_pkg::item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output fmd_pkg::result_t out_res
);
	import fmd_pkg::*;

	localparam int CNT_W = $clog2(HDR_BYTES + PAYLOAD_CAP + 1);
	localparam logic [LIMIT_W-1:0] MAX_LIM = LIMIT_W'(PAYLOAD_CAP);

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [2:0] status_q, status_n;
	logic [7:0] hdr_q [HDR_BYTES];
	logic [7:0] hdr_n [HDR_BYTES];
	logic hdr_wr;
	logic advance;
	logic out_valid_q;
	result_t res_q, res_n;

	logic [LIMIT_W-1:0] lim;
	logic [31:0] req_w, len_w;
	logic [7:0] ty;
	logic magic_ok, rsv_ok, ty_ok, ty_range;
	logic [CNT_W-1:0] pay_cnt;

	// One item moves through when the result register is free or being emptied.
	assign in_ready = !out_valid_q || out_ready;
	assign advance = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_res = res_q;

	assign lim = (size_limit < MAX_LIM) ? size_limit : MAX_LIM;
	assign hdr_wr = (in_item.command == CMD_DATA) && (status_q == ST_INCOMPLETE) &&
		(cnt_q < CNT_W'(HDR_BYTES));

	// Header view with this item's byte already in place.
	always_comb begin
		hdr_n = hdr_q;
		if (hdr_wr) begin
			hdr_n[cnt_q[HDR_IDX_W-1:0]] = in_item.data_byte;
		end
	end

	assign ty = hdr_n[5];
	assign req_w = {hdr_n[8], hdr_n[9], hdr_n[10], hdr_n[11]};
	assign len_w = {hdr_n[12], hdr_n[13], hdr_n[14], hdr_n[15]};
	assign magic_ok = (hdr_n[0] == MAGIC_B0) && (hdr_n[1] == MAGIC_B1) &&
		(hdr_n[2] == MAGIC_B2) && (hdr_n[3] == MAGIC_B3);
	assign rsv_ok = (hdr_n[6] == 8'd0) && (hdr_n[7] == 8'd0);
	assign ty_range = (ty >= TYPE_MIN) && (ty <= TYPE_MAX);
	assign ty_ok = ty_range && (((ty == TYPE_NOREQ_A) || (ty == TYPE_NOREQ_B)) ?
		(req_w == 32'd0) : (req_w != 32'd0));

	// Payload bytes consumed once this byte is counted.
	assign pay_cnt = cnt_q - CNT_W'(HDR_BYTES - 1);

	// Next decoder state and the result for this item.
	always_comb begin
		cnt_n = cnt_q;
		status_n = status_q;
		res_n = '0;
		if (in_item.command == CMD_RESTART) begin
			cnt_n = '0;
			status_n = ST_INCOMPLETE;
		end else if (status_q == ST_INCOMPLETE) begin
			res_n.accepted = 1'b1;
			cnt_n = cnt_q + CNT_W'(1);
			if (hdr_wr) begin
				if (cnt_q == CNT_W'(HDR_BYTES - 1)) begin
					if (!magic_ok || !rsv_ok || !ty_ok) begin
						status_n = ST_MALFORMED;
					end else if (hdr_n[4] != VERSION_OK) begin
						status_n = ST_BADVER;
					end else if (len_w > 32'(lim)) begin
						status_n = ST_OVERSIZED;
					end else if (len_w == 32'd0) begin
						status_n = ST_READY;
					end
				end
			end else begin
				res_n.payload_valid = 1'b1;
				res_n.payload_byte = in_item.data_byte;
				if (32'(pay_cnt) >= len_w) begin
					status_n = ST_READY;
				end
			end
		end
		res_n.status = status_n;
		if (cnt_n >= CNT_W'(HDR_BYTES)) begin
			res_n.header_valid = (status_n == ST_INCOMPLETE) || (status_n == ST_READY);
			res_n.frame_type = ty;
			res_n.request_id = req_w;
			res_n.payload_length = len_w;
		end
	end

	// Decoder state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			status_q <= ST_INCOMPLETE;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
			if (advance) begin
				cnt_q <= cnt_n;
				status_q <= status_n;
			end
		end
	end

	// Header bytes and result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
			if (hdr_wr) begin
				hdr_q[cnt_q[HDR_IDX_W-1:0]] <= in_item.data_byte;
			end
		end
	end

endmodule

>>> tb/tb_framed_message_decoder.sv
`timescale 1ns / 100ps

module tb_framed_message_decoder;
	import fmd_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int PHASE_ITEMS = 160;
	localparam int PHASES = 5;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	// Result fields inside m_axis_tdata, lowest bit first.
	localparam int FIELDS = 9;
	localparam int FIELD_LO [FIELDS] = '{0, 1, 4, 5, 13, 14, 22, 54, 86};
	localparam int FIELD_W [FIELDS] = '{1, 3, 1, 8, 1, 8, 32, 32, 2};

	typedef struct packed {
		logic acc;
		logic [2:0] st;
		logic pv;
		logic [7:0] pb;
		logic hv;
		logic [7:0] ftype;
		logic [31:0] req;
		logic [31:0] len;
	} decode_out_t;

	typedef struct {
		logic cmd;
		logic [7:0] b;
		bit typed;
		decode_out_t want;
	} stim_row_t;

	typedef enum int {
		FR_GOOD,
		FR_MALFORMED,
		FR_BADVER,
		FR_OVERSIZED,
		FR_TRUNCATED,
		FR_NOISE
	} frame_kind_e;

	typedef enum int {
		BREAK_MAGIC,
		BREAK_RESERVED,
		BREAK_TYPE,
		BREAK_REQUEST
	} defect_e;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;

	// Decoder state as the checker sees it.
	logic [LIMIT_W-1:0] limit_reg;
	int unsigned frame_bytes;
	logic [2:0] frame_status;
	logic [7:0] hdr [HDR_BYTES];

	logic [OUT_TDATA_W-1:0] pending_results [$];
	stim_row_t rows [$];
	string field_names [FIELDS] = '{"accepted", "status", "payload_valid", "payload_byte",
		"header_valid", "frame_type", "request_id", "payload_length", "pad"};

	int mismatch_count = 0;
	int cycle_count = 0;
	int phase_items;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	framed_message_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] hdr_word(int pos);
		return {hdr[pos], hdr[pos+1], hdr[pos+2], hdr[pos+3]};
	endfunction

	// The size limit in force never exceeds the payload maximum.
	function automatic int unsigned size_cap();
		return (limit_reg < PAYLOAD_CAP_DEF) ? int'(limit_reg) : PAYLOAD_CAP_DEF;
	endfunction

	// Header checks run in priority order: malformed, version, size.
	function automatic void judge_header();
		logic [7:0] ft;
		logic [31:0] req;
		logic [31:0] len;
		bit magic_ok;
		bit rsv_ok;
		bit kind_ok;
		ft = hdr[5];
		req = hdr_word(8);
		len = hdr_word(12);
		magic_ok = hdr[0] == MAGIC_B0 && hdr[1] == MAGIC_B1 &&
			hdr[2] == MAGIC_B2 && hdr[3] == MAGIC_B3;
		rsv_ok = hdr[6] == 8'd0 && hdr[7] == 8'd0;
		if (ft < TYPE_MIN || ft > TYPE_MAX)
			kind_ok = 1'b0;
		else if (ft == TYPE_NOREQ_A || ft == TYPE_NOREQ_B)
			kind_ok = (req == 32'd0);
		else
			kind_ok = (req != 32'd0);
		if (!magic_ok || !rsv_ok || !kind_ok)
			frame_status = ST_MALFORMED;
		else if (hdr[4] != VERSION_OK)
			frame_status = ST_BADVER;
		else if (len > size_cap())
			frame_status = ST_OVERSIZED;
		else if (len == 32'd0)
			frame_status = ST_READY;
	endfunction

	// Advance the decoder by one byte or command and return its result.
	function automatic decode_out_t decode_byte(logic cmd, logic [7:0] b);
		decode_out_t o;
		o = '0;
		if (cmd == CMD_RESTART) begin
			frame_bytes = 0;
			frame_status = ST_INCOMPLETE;
		end else if (frame_status == ST_INCOMPLETE) begin
			o.acc = 1'b1;
			if (frame_bytes < HDR_BYTES) begin
				hdr[frame_bytes] = b;
				frame_bytes++;
				if (frame_bytes == HDR_BYTES)
					judge_header();
			end else begin
				o.pv = 1'b1;
				o.pb = b;
				frame_bytes++;
				if (frame_bytes - HDR_BYTES >= hdr_word(12))
					frame_status = ST_READY;
			end
		end
		o.st = frame_status;
		if (frame_bytes >= HDR_BYTES) begin
			o.hv = (frame_status == ST_INCOMPLETE || frame_status == ST_READY);
			o.ftype = hdr[5];
			o.req = hdr_word(8);
			o.len = hdr_word(12);
		end
		return o;
	endfunction

	function automatic logic [OUT_TDATA_W-1:0] pack_result(decode_out_t o);
		return {2'b00, o.len, o.req, o.ftype, o.hv, o.pb, o.pv, o.st, o.acc};
	endfunction

	function automatic decode_out_t make_out(logic acc, logic [2:0] st, logic hv,
		logic [7:0] ftype, logic [31:0] req, logic [31:0] len);
		decode_out_t o;
		o = '0;
		o.acc = acc;
		o.st = st;
		o.hv = hv;
		o.ftype = ftype;
		o.req = req;
		o.len = len;
		return o;
	endfunction

	function automatic void add_row(logic cmd, logic [7:0] b, bit typed = 1'b0,
		decode_out_t want = '0);
		stim_row_t r;
		r.cmd = cmd;
		r.b = b;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endfunction

	function automatic void note_mismatch(string what, logic [87:0] want, logic [87:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endfunction

	// Compare one result transfer against the oldest expectation.
	function automatic void check_result(logic [OUT_TDATA_W-1:0] got);
		logic [OUT_TDATA_W-1:0] want;
		logic [OUT_TDATA_W-1:0] mask;
		if (pending_results.size() == 0) begin
			note_mismatch("unexpected result", '0, got);
			return;
		end
		want = pending_results.pop_front();
		for (int f = 0; f < FIELDS; f++) begin
			mask = ~({OUT_TDATA_W{1'b1}} << FIELD_W[f]);
			if (((want >> FIELD_LO[f]) & mask) != ((got >> FIELD_LO[f]) & mask))
				note_mismatch(field_names[f], (want >> FIELD_LO[f]) & mask,
					(got >> FIELD_LO[f]) & mask);
		end
	endfunction

	// Offer one transfer, then record what the decoder should answer.
	task automatic send_item(logic cmd, logic [7:0] b, bit typed = 1'b0,
		decode_out_t want = '0);
		decode_out_t o;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		o = decode_byte(cmd, b);
		pending_results.push_back(pack_result(typed ? want : o));
		phase_items++;
	endtask

	// Write the size limit once every result is back and the pipe is empty.
	task automatic set_size_limit(logic [LIMIT_W-1:0] value);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_reg = value;
	endtask

	// One frame: restart, sixteen header bytes, then some payload; the noise kind sends random bytes and restarts instead.
	task automatic send_frame(frame_kind_e kind);
		logic [7:0] hb [HDR_BYTES];
		logic [7:0] ftype;
		logic [7:0] version;
		logic [31:0] req;
		logic [31:0] len;
		int unsigned cap;
		int unsigned n_pay;
		int i;
		defect_e defect;
		cap = size_cap();
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 20))
				send_item(($urandom_range(9) == 0) ? CMD_RESTART : CMD_DATA, 8'($urandom));
			return;
		end
		version = VERSION_OK;
		ftype = 8'($urandom_range(TYPE_MIN, TYPE_MAX));
		do req = $urandom; while (req == 32'd0);
		if ($urandom_range(7) == 0)
			req = 32'hFFFF_FFFF;
		if (ftype == TYPE_NOREQ_A || ftype == TYPE_NOREQ_B)
			req = 32'd0;
		if (cap <= 64 && $urandom_range(3) == 0)
			len = cap;
		else
			len = $urandom_range(0, (cap < 6) ? cap : 6);
		n_pay = len;
		case (kind)
			FR_MALFORMED: begin
				defect = defect_e'($urandom_range(3));
				if (defect == BREAK_TYPE) begin
					ftype = ($urandom_range(1) == 0) ? 8'd0 :
						8'($urandom_range(TYPE_MAX + 1, 255));
					req = $urandom;
				end else if (defect == BREAK_REQUEST) begin
					if (ftype == TYPE_NOREQ_A || ftype == TYPE_NOREQ_B) begin
						do req = $urandom; while (req == 32'd0);
					end else begin
						req = 32'd0;
					end
				end
				// A bad version must not hide a malformed header.
				if ($urandom_range(1) == 0)
					do version = 8'($urandom); while (version == VERSION_OK);
			end
			FR_BADVER: begin
				do version = 8'($urandom); while (version == VERSION_OK);
				if ($urandom_range(1) == 0)
					len = cap + 1;
			end
			FR_OVERSIZED: begin
				if ($urandom_range(1) == 0)
					len = cap + 1;
				else
					len = $urandom_range(cap + 1, 32'hFFFF_FFFF);
			end
			FR_TRUNCATED: begin
				if (cap >= 2)
					len = ($urandom_range(1) == 0) ? cap : $urandom_range(2, cap);
				else
					len = cap;
				n_pay = (len > 0) ? $urandom_range(0, (len > 8) ? 8 : len - 1) : 0;
			end
			default: begin
			end
		endcase
		hb[0] = MAGIC_B0;
		hb[1] = MAGIC_B1;
		hb[2] = MAGIC_B2;
		hb[3] = MAGIC_B3;
		hb[4] = version;
		hb[5] = ftype;
		hb[6] = 8'd0;
		hb[7] = 8'd0;
		{hb[8], hb[9], hb[10], hb[11]} = req;
		{hb[12], hb[13], hb[14], hb[15]} = len;
		if (kind == FR_MALFORMED && defect == BREAK_MAGIC)
			hb[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
		if (kind == FR_MALFORMED && defect == BREAK_RESERVED)
			hb[$urandom_range(6, 7)] = 8'($urandom_range(1, 255));

		send_item(CMD_RESTART, 8'($urandom));
		for (i = 0; i < HDR_BYTES; i++)
			send_item(CMD_DATA, hb[i]);
		for (i = 0; i < n_pay && frame_status == ST_INCOMPLETE; i++)
			send_item(CMD_DATA, 8'($urandom));
		// Bytes offered after the frame has ended are refused.
		if (frame_status != ST_INCOMPLETE && $urandom_range(2) == 0)
			repeat ($urandom_range(1, 2)) send_item(CMD_DATA, 8'($urandom));
	endtask

	function automatic frame_kind_e pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 45) return FR_GOOD;
		if (r < 60) return FR_MALFORMED;
		if (r < 68) return FR_BADVER;
		if (r < 78) return FR_OVERSIZED;
		if (r < 88) return FR_TRUNCATED;
		return FR_NOISE;
	endfunction

	// Result side: take transfers, stall at random, and hold off once for long.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus: directed frame first, then random frames under several limits.
	initial begin
		logic [LIMIT_W-1:0] limits [PHASES];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = CMD_DATA;
		s_axis_tdata = 8'd0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		limit_reg = LIMIT_RESET;
		frame_bytes = 0;
		frame_status = ST_INCOMPLETE;
		foreach (hdr[k])
			hdr[k] = 8'd0;
		limits[0] = LIMIT_RESET;
		limits[1] = '0;
		limits[2] = '1;
		limits[3] = LIMIT_W'($urandom_range(1, 40));
		limits[4] = 17'd65535;

		// Restart, then a zero-length type-5 header that is ready at once,
		// a refused byte, and a header cut short by a restart.
		add_row(CMD_RESTART, 8'hFF, 1'b1,
			make_out(1'b0, ST_INCOMPLETE, 1'b0, 8'd0, 32'd0, 32'd0));
		add_row(CMD_DATA, MAGIC_B0);
		add_row(CMD_DATA, MAGIC_B1);
		add_row(CMD_DATA, MAGIC_B2);
		add_row(CMD_DATA, MAGIC_B3);
		add_row(CMD_DATA, VERSION_OK);
		add_row(CMD_DATA, TYPE_NOREQ_B);
		repeat (9) add_row(CMD_DATA, 8'h00);
		add_row(CMD_DATA, 8'h00, 1'b1,
			make_out(1'b1, ST_READY, 1'b1, TYPE_NOREQ_B, 32'd0, 32'd0));
		add_row(CMD_DATA, 8'hFF, 1'b1,
			make_out(1'b0, ST_READY, 1'b1, TYPE_NOREQ_B, 32'd0, 32'd0));
		add_row(CMD_RESTART, 8'h00, 1'b1,
			make_out(1'b0, ST_INCOMPLETE, 1'b0, 8'd0, 32'd0, 32'd0));
		add_row(CMD_DATA, 8'hFF);
		add_row(CMD_DATA, 8'h00);
		add_row(CMD_DATA, 8'hA5);
		add_row(CMD_DATA, 8'h5A);
		add_row(CMD_DATA, 8'h80);
		add_row(CMD_RESTART, 8'h7F, 1'b1,
			make_out(1'b0, ST_INCOMPLETE, 1'b0, 8'd0, 32'd0, 32'd0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 78 : 0;
			recv_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 27 : 0;
			if (ph > 0)
				set_size_limit(limits[ph]);
			phase_items = 0;
			if (ph == 0) begin
				foreach (rows[r])
					send_item(rows[r].cmd, rows[r].b, rows[r].typed, rows[r].want);
			end
			if (ph == PHASES - 1)
				hold_request = 1'b1;
			while (phase_items < PHASE_ITEMS)
				send_frame(pick_kind());
			s_axis_tvalid <= 1'b0;
		end

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
